@@ design/cecr_pkg.sv @@
// Package for the circle elastic collision response unit.
// Holds payload types, pipeline sizes and fixed-point helper functions.
// No dependencies.
package cecr_pkg;

   localparam int SQRT_STEPS = 32;   // one root bit per stage
   localparam int SQRT_IN_W  = 63;   // ax^2 + ay^2
   localparam int LEN_W      = 32;
   localparam int MAG_W      = 31;   // normalized |d| components
   localparam int DIV_STEPS  = 31;   // one quotient bit per stage
   localparam int QUO_W      = 31;
   localparam int DIVIDEND_W = 62;
   localparam int DIVISOR_W  = 32;
   localparam int FRAC_N     = 30;   // Q2.30 normal
   localparam int FRAC_K     = 29;   // Q2.29 mass ratio
   localparam int WIDE_W     = 68;

   localparam logic [QUO_W-1:0] K_HALF = QUO_W'(1) << FRAC_K;
   localparam logic [QUO_W-1:0] K_ONE  = QUO_W'(1) << FRAC_N;

   localparam logic signed [WIDE_W-1:0] LIM32   = 68'sh0_FFFF_FFFF;
   localparam logic signed [WIDE_W-1:0] S32_MAX = 68'sh0_7FFF_FFFF;
   localparam logic signed [WIDE_W-1:0] S32_MIN = -68'sh0_8000_0000;

   typedef struct packed {
      logic signed [31:0] pos_a_x;
      logic signed [31:0] pos_a_y;
      logic signed [31:0] vel_a_x;
      logic signed [31:0] vel_a_y;
      logic [30:0]        mass_a;
      logic signed [31:0] pos_b_x;
      logic signed [31:0] pos_b_y;
      logic signed [31:0] vel_b_x;
      logic signed [31:0] vel_b_y;
      logic [30:0]        mass_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_vel_a_x;
      logic signed [31:0] new_vel_a_y;
      logic signed [31:0] new_vel_b_x;
      logic signed [31:0] new_vel_b_y;
      logic               centers_coincide;
   } rsp_type;

   // divide by 2^s, round to nearest, ties away from zero
   function automatic logic signed [WIDE_W-1:0] round_shift(
      input logic signed [WIDE_W-1:0] x, input int unsigned s);
      logic [WIDE_W-1:0] mag;
      logic [WIDE_W-1:0] res;
      mag = x[WIDE_W-1] ? WIDE_W'(-x) : WIDE_W'(x);
      res = (mag + (WIDE_W'(1) << (s - 1))) >> s;
      return x[WIDE_W-1] ? -$signed(res) : $signed(res);
   endfunction

   function automatic logic signed [32:0] clamp_lim(input logic signed [WIDE_W-1:0] x);
      logic signed [WIDE_W-1:0] r;
      r = x;
      if (x < -LIM32) r = -LIM32;
      if (x > LIM32)  r = LIM32;
      return r[32:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] x);
      logic signed [WIDE_W-1:0] r;
      r = x;
      if (x < S32_MIN) r = S32_MIN;
      if (x > S32_MAX) r = S32_MAX;
      return r[31:0];
   endfunction

endpackage

@@ design/circle_elastic_collision_response_unit.sv @@
// Top level of the circle elastic collision response unit.
// Depends on cecr_pkg, cecr_sqrt and cecr_div.
//
//  channel | ports                        | carries
//  --------+------------------------------+---------------------------------
//  request | req_valid/req_ready/req_data | both disks: centers, vels, masses
//  result  | rsp_valid/rsp_ready/rsp_data | both new velocities, coincide flag
//
// One pair enters per cycle while the pipeline is not held (see below). The depth is
// set by the 32-stage square root and the 31-stage dividers, one bit a stage.
// Reset clears only the valid bits; the data registers are not reset.
// The whole pipeline holds while the output register is full and not taken.
module circle_elastic_collision_response_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cecr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cecr_pkg::rsp_type rsp_data
);

   localparam int ST_PREP = 3 + cecr_pkg::SQRT_STEPS;
   localparam int ST_N1   = ST_PREP + cecr_pkg::DIV_STEPS + 1;
   localparam int LAT     = ST_N1 + 12;
   localparam int COEF_N  = 8;
   localparam int MW      = cecr_pkg::MAG_W;
   localparam int QW      = cecr_pkg::QUO_W;
   localparam int WW      = cecr_pkg::WIDE_W;

   typedef struct packed {
      logic               coincide;
      logic signed [31:0] vax;
      logic signed [31:0] vay;
      logic signed [31:0] vbx;
      logic signed [31:0] vby;
   } pass_type;

   typedef struct packed {
      logic          sx;
      logic          sy;
      logic [MW-1:0] ax;
      logic [MW-1:0] ay;
      logic [30:0]   mb;
      logic [31:0]   msum;
   } geo_type;

   typedef struct packed {
      logic sx;
      logic sy;
      logic mzero;
   } dside_type;

   typedef struct packed {
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic [QW-1:0]      ka;
      logic [QW-1:0]      kb;
   } coef_type;

   logic en;
   logic     valid_ff [LAT];
   pass_type pass_ff  [LAT-1];
   geo_type  geo_ff   [ST_PREP];
   dside_type dside_ff [cecr_pkg::DIV_STEPS+1];
   coef_type coef_ff  [COEF_N];

   assign en        = !valid_ff[LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = valid_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) valid_ff[i] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i < LAT; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   // stage 0: center difference, magnitude, common halving
   logic signed [32:0] dx, dy;
   logic [32:0]        mx, my;
   logic               big;
   geo_type            geo_in;
   pass_type           pass_in;

   always_comb begin
      dx = 33'(req_data.pos_b_x) - 33'(req_data.pos_a_x);
      dy = 33'(req_data.pos_b_y) - 33'(req_data.pos_a_y);
      mx = dx[32] ? 33'(-dx) : 33'(dx);
      my = dy[32] ? 33'(-dy) : 33'(dy);
      big = mx[31] | my[31];
      geo_in.sx   = dx[32];
      geo_in.sy   = dy[32];
      geo_in.ax   = big ? mx[31:1] : mx[30:0];
      geo_in.ay   = big ? my[31:1] : my[30:0];
      geo_in.mb   = req_data.mass_b;
      geo_in.msum = {1'b0, req_data.mass_a} + {1'b0, req_data.mass_b};
      pass_in.coincide = (dx == '0) && (dy == '0);
      pass_in.vax = req_data.vel_a_x;
      pass_in.vay = req_data.vel_a_y;
      pass_in.vbx = req_data.vel_b_x;
      pass_in.vby = req_data.vel_b_y;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pass_ff[0] <= pass_in;
         for (int i = 1; i < LAT - 1; i++) pass_ff[i] <= pass_ff[i-1];
         geo_ff[0] <= geo_in;
         for (int i = 1; i < ST_PREP; i++) geo_ff[i] <= geo_ff[i-1];
      end
   end

   // stages 1 and 2: squared length
   logic [2*MW-1:0] sq_x_ff, sq_y_ff;
   logic [cecr_pkg::SQRT_IN_W-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_x_ff <= geo_ff[0].ax * geo_ff[0].ax;
         sq_y_ff <= geo_ff[0].ay * geo_ff[0].ay;
         sum_ff  <= cecr_pkg::SQRT_IN_W'(sq_x_ff) + cecr_pkg::SQRT_IN_W'(sq_y_ff);
      end
   end

   logic [cecr_pkg::LEN_W-1:0] len;

   cecr_sqrt u_sqrt (
      .clock    (clock),
      .en       (en),
      .value_in (sum_ff),
      .len_out  (len)
   );

   // prep stage: rounded dividends for the normal and the mass ratio
   logic [cecr_pkg::DIVIDEND_W-1:0] dvd_x_ff, dvd_y_ff, dvd_m_ff;
   logic [cecr_pkg::DIVISOR_W-1:0]  len_ff, msum_ff;
   geo_type                         gp;

   assign gp = geo_ff[ST_PREP-1];

   always_ff @(posedge clock) begin
      if (en) begin
         dvd_x_ff <= {1'b0, gp.ax, 30'b0} + cecr_pkg::DIVIDEND_W'(len >> 1);
         dvd_y_ff <= {1'b0, gp.ay, 30'b0} + cecr_pkg::DIVIDEND_W'(len >> 1);
         dvd_m_ff <= {1'b0, gp.mb, 30'b0} + cecr_pkg::DIVIDEND_W'(gp.msum >> 1);
         len_ff   <= len;
         msum_ff  <= gp.msum;
         dside_ff[0] <= '{sx: gp.sx, sy: gp.sy, mzero: gp.msum == '0};
         for (int i = 1; i <= cecr_pkg::DIV_STEPS; i++) dside_ff[i] <= dside_ff[i-1];
      end
   end

   logic [QW-1:0] q_x, q_y, q_m;

   cecr_div u_div_x (
      .clock (clock), .en (en), .dividend_in (dvd_x_ff), .divisor_in (len_ff),
      .quotient_out (q_x)
   );
   cecr_div u_div_y (
      .clock (clock), .en (en), .dividend_in (dvd_y_ff), .divisor_in (len_ff),
      .quotient_out (q_y)
   );
   cecr_div u_div_m (
      .clock (clock), .en (en), .dividend_in (dvd_m_ff), .divisor_in (msum_ff),
      .quotient_out (q_m)
   );

   // N1: signed normal and mass ratios
   coef_type  coef_in;
   dside_type ds;

   always_comb begin
      ds = dside_ff[cecr_pkg::DIV_STEPS];
      coef_in.nx = ds.sx ? -$signed(32'(q_x)) : $signed(32'(q_x));
      coef_in.ny = ds.sy ? -$signed(32'(q_y)) : $signed(32'(q_y));
      coef_in.ka = ds.mzero ? cecr_pkg::K_HALF : q_m;
      coef_in.kb = cecr_pkg::K_ONE - coef_in.ka;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         coef_ff[0] <= coef_in;
         for (int i = 1; i < COEF_N; i++) coef_ff[i] <= coef_ff[i-1];
      end
   end

   // N2..N4: project both velocities on normal and tangent
   logic signed [63:0] pa_n1_ff, pa_n2_ff, pa_t1_ff, pa_t2_ff;
   logic signed [63:0] pb_n1_ff, pb_n2_ff, pb_t1_ff, pb_t2_ff;
   logic signed [64:0] vna_s_ff, vnb_s_ff, vta_s_ff, vtb_s_ff;
   logic signed [34:0] vna_ff, vnb_ff, vta_r_ff, vtb_r_ff;
   pass_type pv;
   coef_type c1;

   assign pv = pass_ff[ST_N1];
   assign c1 = coef_ff[0];

   always_ff @(posedge clock) begin
      if (en) begin
         pa_n1_ff <= pv.vax * c1.nx;
         pa_n2_ff <= pv.vay * c1.ny;
         pa_t1_ff <= pv.vay * c1.nx;
         pa_t2_ff <= pv.vax * c1.ny;
         pb_n1_ff <= pv.vbx * c1.nx;
         pb_n2_ff <= pv.vby * c1.ny;
         pb_t1_ff <= pv.vby * c1.nx;
         pb_t2_ff <= pv.vbx * c1.ny;
         vna_s_ff <= 65'(pa_n1_ff) + 65'(pa_n2_ff);
         vnb_s_ff <= 65'(pb_n1_ff) + 65'(pb_n2_ff);
         vta_s_ff <= 65'(pa_t1_ff) - 65'(pa_t2_ff);
         vtb_s_ff <= 65'(pb_t1_ff) - 65'(pb_t2_ff);
         vna_ff   <= 35'(cecr_pkg::round_shift(WW'(vna_s_ff), cecr_pkg::FRAC_N));
         vnb_ff   <= 35'(cecr_pkg::round_shift(WW'(vnb_s_ff), cecr_pkg::FRAC_N));
         vta_r_ff <= 35'(cecr_pkg::round_shift(WW'(vta_s_ff), cecr_pkg::FRAC_N));
         vtb_r_ff <= 35'(cecr_pkg::round_shift(WW'(vtb_s_ff), cecr_pkg::FRAC_N));
      end
   end

   // N5..N8: 1D elastic exchange along the normal
   logic signed [35:0] da_ff, db_ff;
   logic signed [34:0] vna5_ff, vnb5_ff, vna6_ff, vnb6_ff;
   logic signed [32:0] vta5_ff, vtb5_ff, vta6_ff, vtb6_ff, vta7_ff, vtb7_ff;
   logic signed [32:0] vta8_ff, vtb8_ff, ua_ff, ub_ff;
   logic signed [WW-1:0] ka_p_ff, kb_p_ff;
   logic signed [36:0] ua_s_ff, ub_s_ff;
   logic signed [31:0] ka_s, kb_s;

   assign ka_s = $signed({1'b0, coef_ff[4].ka});
   assign kb_s = $signed({1'b0, coef_ff[4].kb});

   always_ff @(posedge clock) begin
      if (en) begin
         da_ff   <= 36'(vnb_ff) - 36'(vna_ff);
         db_ff   <= 36'(vna_ff) - 36'(vnb_ff);
         vna5_ff <= vna_ff;
         vnb5_ff <= vnb_ff;
         vta5_ff <= cecr_pkg::clamp_lim(WW'(vta_r_ff));
         vtb5_ff <= cecr_pkg::clamp_lim(WW'(vtb_r_ff));

         ka_p_ff <= da_ff * ka_s;
         kb_p_ff <= db_ff * kb_s;
         vna6_ff <= vna5_ff;
         vnb6_ff <= vnb5_ff;
         vta6_ff <= vta5_ff;
         vtb6_ff <= vtb5_ff;

         ua_s_ff <= 37'(vna6_ff) + 37'(cecr_pkg::round_shift(ka_p_ff, cecr_pkg::FRAC_K));
         ub_s_ff <= 37'(vnb6_ff) + 37'(cecr_pkg::round_shift(kb_p_ff, cecr_pkg::FRAC_K));
         vta7_ff <= vta6_ff;
         vtb7_ff <= vtb6_ff;

         ua_ff   <= cecr_pkg::clamp_lim(WW'(ua_s_ff));
         ub_ff   <= cecr_pkg::clamp_lim(WW'(ub_s_ff));
         vta8_ff <= vta7_ff;
         vtb8_ff <= vtb7_ff;
      end
   end

   // N9..N12: rebuild velocities from normal and tangent parts
   logic signed [64:0] fa_nu_ff, fa_nt_ff, fa_yu_ff, fa_yt_ff;
   logic signed [64:0] fb_nu_ff, fb_nt_ff, fb_yu_ff, fb_yt_ff;
   logic signed [65:0] sax_ff, say_ff, sbx_ff, sby_ff;
   logic signed [36:0] rax_ff, ray_ff, rbx_ff, rby_ff;
   cecr_pkg::rsp_type rsp_ff;
   coef_type c9;
   pass_type pf;

   assign c9 = coef_ff[COEF_N-1];
   assign pf = pass_ff[LAT-2];

   always_ff @(posedge clock) begin
      if (en) begin
         fa_nu_ff <= c9.nx * ua_ff;
         fa_nt_ff <= c9.ny * vta8_ff;
         fa_yu_ff <= c9.ny * ua_ff;
         fa_yt_ff <= c9.nx * vta8_ff;
         fb_nu_ff <= c9.nx * ub_ff;
         fb_nt_ff <= c9.ny * vtb8_ff;
         fb_yu_ff <= c9.ny * ub_ff;
         fb_yt_ff <= c9.nx * vtb8_ff;

         sax_ff <= 66'(fa_nu_ff) - 66'(fa_nt_ff);
         say_ff <= 66'(fa_yu_ff) + 66'(fa_yt_ff);
         sbx_ff <= 66'(fb_nu_ff) - 66'(fb_nt_ff);
         sby_ff <= 66'(fb_yu_ff) + 66'(fb_yt_ff);

         rax_ff <= 37'(cecr_pkg::round_shift(WW'(sax_ff), cecr_pkg::FRAC_N));
         ray_ff <= 37'(cecr_pkg::round_shift(WW'(say_ff), cecr_pkg::FRAC_N));
         rbx_ff <= 37'(cecr_pkg::round_shift(WW'(sbx_ff), cecr_pkg::FRAC_N));
         rby_ff <= 37'(cecr_pkg::round_shift(WW'(sby_ff), cecr_pkg::FRAC_N));

         // coincident centers pass the velocities through
         if (pf.coincide) begin
            rsp_ff.new_vel_a_x <= pf.vax;
            rsp_ff.new_vel_a_y <= pf.vay;
            rsp_ff.new_vel_b_x <= pf.vbx;
            rsp_ff.new_vel_b_y <= pf.vby;
         end else begin
            rsp_ff.new_vel_a_x <= cecr_pkg::sat32(WW'(rax_ff));
            rsp_ff.new_vel_a_y <= cecr_pkg::sat32(WW'(ray_ff));
            rsp_ff.new_vel_b_x <= cecr_pkg::sat32(WW'(rbx_ff));
            rsp_ff.new_vel_b_y <= cecr_pkg::sat32(WW'(rby_ff));
         end
         rsp_ff.centers_coincide <= pf.coincide;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ design/cecr_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on cecr_pkg for sizes.
module cecr_sqrt (
   input  logic                             clock,
   input  logic                             en,
   input  logic [cecr_pkg::SQRT_IN_W-1:0]   value_in,
   output logic [cecr_pkg::LEN_W-1:0]       len_out
);

   localparam int SW = cecr_pkg::SQRT_IN_W;
   localparam int LW = cecr_pkg::LEN_W;
   localparam int TW = SW + 2;

   logic [SW-1:0] rem_ff  [cecr_pkg::SQRT_STEPS];
   logic [LW-1:0] root_ff [cecr_pkg::SQRT_STEPS];

   for (genvar k = 0; k < cecr_pkg::SQRT_STEPS; k++) begin : g_step
      localparam int Bit = cecr_pkg::SQRT_STEPS - 1 - k;
      logic [SW-1:0] rem_prev;
      logic [LW-1:0] root_prev;
      logic [TW-1:0] trial;
      logic [TW-1:0] rem_ext;

      if (k == 0) begin : g_first
         assign rem_prev  = value_in;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // trial = 2*root*2^bit + 2^(2*bit)
      assign trial   = (TW'(root_prev) << (Bit + 1)) + (TW'(1) << (2 * Bit));
      assign rem_ext = TW'(rem_prev);

      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_ext >= trial) begin
               rem_ff[k]  <= SW'(rem_ext - trial);
               root_ff[k] <= root_prev | (LW'(1) << Bit);
            end else begin
               rem_ff[k]  <= rem_prev;
               root_ff[k] <= root_prev;
            end
         end
      end
   end

   assign len_out = root_ff[cecr_pkg::SQRT_STEPS-1];

endmodule

@@ design/cecr_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit QUO_W bits. Depends on cecr_pkg for sizes.
module cecr_div (
   input  logic                              clock,
   input  logic                              en,
   input  logic [cecr_pkg::DIVIDEND_W-1:0]   dividend_in,
   input  logic [cecr_pkg::DIVISOR_W-1:0]    divisor_in,
   output logic [cecr_pkg::QUO_W-1:0]        quotient_out
);

   localparam int QW = cecr_pkg::QUO_W;
   localparam int DW = cecr_pkg::DIVISOR_W;
   localparam int NW = cecr_pkg::DIVIDEND_W;

   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] low_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [DW-1:0] dsr_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_step
      localparam int Bit = QW - 1 - k;
      logic [DW-1:0] rem_prev;
      logic [QW-1:0] low_prev;
      logic [QW-1:0] quo_prev;
      logic [DW-1:0] dsr_prev;
      logic [DW:0]   shifted;
      logic [DW:0]   diff;
      logic          fits;

      if (k == 0) begin : g_first
         assign rem_prev = DW'(dividend_in[NW-1:QW]);
         assign low_prev = dividend_in[QW-1:0];
         assign quo_prev = '0;
         assign dsr_prev = divisor_in;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign low_prev = low_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign dsr_prev = dsr_ff[k-1];
      end

      assign shifted = {rem_prev, low_prev[Bit]};
      assign diff    = shifted - {1'b0, dsr_prev};
      assign fits    = shifted >= {1'b0, dsr_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= fits ? diff[DW-1:0] : shifted[DW-1:0];
            quo_ff[k] <= quo_prev | (QW'(fits) << Bit);
            low_ff[k] <= low_prev;
            dsr_ff[k] <= dsr_prev;
         end
      end
   end

   assign quotient_out = quo_ff[QW-1];

endmodule

@@ test/circle_elastic_collision_response_unit_test.sv @@
// Testbench for circle_elastic_collision_response_unit: drives disk pairs and
// checks each result against a fixed-point collision predictor.
// Depends on cecr_pkg and the unit itself.
`timescale 1ns / 1ps

module circle_elastic_collision_response_unit_test;

   localparam int NUM_RANDOM  = 1200;
   localparam int SETTLE_CYC  = 200;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   cecr_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   cecr_pkg::rsp_type rsp_data;

   cecr_pkg::req_type pending_pairs[$];
   cecr_pkg::rsp_type expected_velocities[$];
   int      mismatch_count = 0;
   bit      stimulus_done = 1'b0;
   bit      req_taken = 1'b0;
   int      send_wait = 0;
   int      take_wait = 0;

   circle_elastic_collision_response_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   function automatic longint round_div2(input longint x, input int s);
      longint m;
      m = (x < 0) ? -x : x;
      m = (m + (64'sd1 <<< (s - 1))) >>> s;
      return (x < 0) ? -m : m;
   endfunction

   function automatic longint clip(input longint x, input longint lo, input longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // Products here can exceed 64 bits, so use 128-bit intermediates.
   function automatic logic signed [127:0] rnd128(input logic signed [127:0] x, input int s);
      logic signed [127:0] m;
      m = (x < 0) ? -x : x;
      m = (m + (128'sd1 <<< (s - 1))) >>> s;
      return (x < 0) ? -m : m;
   endfunction

   function automatic longint c128(input logic signed [127:0] x, input longint lo,
                                   input longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return longint'(x);
   endfunction

   function automatic cecr_pkg::rsp_type collide(input cecr_pkg::req_type p);
      cecr_pkg::rsp_type r;
      longint dx, dy, nx, ny, vax, vay, vbx, vby, vna, vnb, vta, vtb, ka, kb, ua, ub;
      longint unsigned ax, ay, len, ma, mb, msum;
      longint lim;
      lim = 64'sh0_FFFF_FFFF;
      vax = p.vel_a_x; vay = p.vel_a_y; vbx = p.vel_b_x; vby = p.vel_b_y;
      dx = longint'(p.pos_b_x) - longint'(p.pos_a_x);
      dy = longint'(p.pos_b_y) - longint'(p.pos_a_y);
      if (dx == 0 && dy == 0) begin
         r.new_vel_a_x = p.vel_a_x; r.new_vel_a_y = p.vel_a_y;
         r.new_vel_b_x = p.vel_b_x; r.new_vel_b_y = p.vel_b_y;
         r.centers_coincide = 1'b1;
         return r;
      end
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      while (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
         ax >>= 1;
         ay >>= 1;
      end
      len = root_floor(ax * ax + ay * ay);
      nx = longint'(((ax << 30) + (len >> 1)) / len);
      ny = longint'(((ay << 30) + (len >> 1)) / len);
      if (dx < 0) nx = -nx;
      if (dy < 0) ny = -ny;
      vna = longint'(rnd128(128'(vax) * nx + 128'(vay) * ny, 30));
      vnb = longint'(rnd128(128'(vbx) * nx + 128'(vby) * ny, 30));
      vta = longint'(rnd128(128'(vay) * nx - 128'(vax) * ny, 30));
      vtb = longint'(rnd128(128'(vby) * nx - 128'(vbx) * ny, 30));
      ma = p.mass_a; mb = p.mass_b;
      msum = ma + mb;
      if (msum == 0) ka = 64'sd1 <<< 29;
      else ka = longint'((((2 * mb) << 29) + (msum >> 1)) / msum);
      kb = (64'sd1 <<< 30) - ka;
      ua = c128(128'(vna) + rnd128(128'(vnb - vna) * ka, 29), -lim, lim);
      ub = c128(128'(vnb) + rnd128(128'(vna - vnb) * kb, 29), -lim, lim);
      vta = clip(vta, -lim, lim);
      vtb = clip(vtb, -lim, lim);
      r.new_vel_a_x = 32'(c128(rnd128(128'(nx) * ua - 128'(ny) * vta, 30),
                               -64'sd2147483648, 64'sd2147483647));
      r.new_vel_a_y = 32'(c128(rnd128(128'(ny) * ua + 128'(nx) * vta, 30),
                               -64'sd2147483648, 64'sd2147483647));
      r.new_vel_b_x = 32'(c128(rnd128(128'(nx) * ub - 128'(ny) * vtb, 30),
                               -64'sd2147483648, 64'sd2147483647));
      r.new_vel_b_y = 32'(c128(rnd128(128'(ny) * ub + 128'(nx) * vtb, 30),
                               -64'sd2147483648, 64'sd2147483647));
      r.centers_coincide = 1'b0;
      return r;
   endfunction

   function automatic logic [31:0] any_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000 + $urandom_range(0, 3);
         1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         2: return $urandom_range(0, 8) - 4;
         default: return $urandom;
      endcase
   endfunction

   // Mostly physical sizes: positions/velocities within +/-0x0200_0000 units.
   function automatic logic [31:0] modest_word();
      return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
   endfunction

   function automatic cecr_pkg::req_type random_pair();
      cecr_pkg::req_type p;
      int      style;
      style = $urandom_range(0, 9);
      if (style < 6) begin
         p.pos_a_x = modest_word(); p.pos_a_y = modest_word();
         p.vel_a_x = modest_word(); p.vel_a_y = modest_word();
         p.pos_b_x = modest_word(); p.pos_b_y = modest_word();
         p.vel_b_x = modest_word(); p.vel_b_y = modest_word();
         p.mass_a = 31'($urandom_range(1, 32'h0100_0000));
         p.mass_b = 31'($urandom_range(1, 32'h0100_0000));
      end else begin
         p.pos_a_x = any_word(); p.pos_a_y = any_word();
         p.vel_a_x = any_word(); p.vel_a_y = any_word();
         p.pos_b_x = any_word(); p.pos_b_y = any_word();
         p.vel_b_x = any_word(); p.vel_b_y = any_word();
         p.mass_a = 31'($urandom_range(1, 32'h7FFF_FFFF));
         p.mass_b = 31'($urandom_range(1, 32'h7FFF_FFFF));
      end
      if (style == 9) begin
         p.pos_b_x = p.pos_a_x;
         p.pos_b_y = p.pos_a_y;
      end
      return p;
   endfunction

   function automatic cecr_pkg::req_type make_pair(input logic [31:0] pax, pay, vax, vay,
                                                   input logic [30:0] ma,
                                                   input logic [31:0] pbx, pby, vbx, vby,
                                                   input logic [30:0] mb);
      cecr_pkg::req_type p;
      p.pos_a_x = pax; p.pos_a_y = pay; p.vel_a_x = vax; p.vel_a_y = vay;
      p.mass_a = ma;
      p.pos_b_x = pbx; p.pos_b_y = pby; p.vel_b_x = vbx; p.vel_b_y = vby;
      p.mass_b = mb;
      return p;
   endfunction

   initial begin
      // head-on, equal masses: velocities swap along the normal
      pending_pairs.push_back(make_pair(0, 0, 32'h0001_0000, 0, 31'h1_0000,
                                        32'h0002_0000, 0, 32'hFFFF_0000, 0, 31'h1_0000));
      // coincident centers, pass through
      pending_pairs.push_back(make_pair(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF,
                                        32'h8000_0000, 31'h7FFF_FFFF, 32'h1234_5678,
                                        32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1));
      // opposite extreme corners, widest difference
      pending_pairs.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1));
      pending_pairs.push_back(make_pair(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000,
                                        1, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 31'h7FFF_FFFF));
      // unit step, diagonal, minimum masses
      pending_pairs.push_back(make_pair(0, 0, 32'hFFFF_FFFF, 1, 1, 1, 1, 0, 32'hFFFF_FFFF, 1));
      pending_pairs.push_back(make_pair(0, 0, 32'h0003_0000, 32'h0004_0000, 31'h5_0000,
                                        32'hFFFF_FFFF, 0, 0, 0, 31'h7FFF_FFFF));
      pending_pairs.push_back(make_pair(5, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                        31'h4000_0000, 5, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h8000_0000, 31'h3FFF_FFFF));
      // heavy vs light, vertical normal
      pending_pairs.push_back(make_pair(0, 32'h0010_0000, 32'h0001_0000, 32'hFFF0_0000,
                                        31'h7FFF_FFFF, 0, 0, 0, 32'h0020_0000, 1));
      for (int i = 0; i < NUM_RANDOM; i++) pending_pairs.push_back(random_pair());
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // record whether the request was taken at the last rising edge
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
   end

   // Driver: present the next pair after a random gap, hold until accepted; also throttle rsp_ready at random.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // hold the pending transaction
         end else if (send_wait > 0) begin
            req_valid <= 1'b0;
            send_wait <= send_wait - 1;
         end else if (pending_pairs.size() > 0) begin
            req_data  <= pending_pairs.pop_front();
            req_valid <= 1'b1;
            send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
         end else begin
            req_valid <= 1'b0;
            stimulus_done <= 1'b1;
         end
         if (take_wait > 0) begin
            rsp_ready <= 1'b0;
            take_wait <= take_wait - 1;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_valid && rsp_ready)
               take_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
         end
      end
   end

   // Monitor: record accepted requests, check accepted results.
   always @(posedge clock) begin
      cecr_pkg::rsp_type got;
      cecr_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) expected_velocities.push_back(collide(req_data));
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (expected_velocities.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected result %h", got);
            end else begin
               want = expected_velocities.pop_front();
               if (got.new_vel_a_x !== want.new_vel_a_x ||
                   got.new_vel_a_y !== want.new_vel_a_y ||
                   got.new_vel_b_x !== want.new_vel_b_x ||
                   got.new_vel_b_y !== want.new_vel_b_y ||
                   got.centers_coincide !== want.centers_coincide) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch: expected a=(%h,%h) b=(%h,%h) c=%b, ",
                               "got a=(%h,%h) b=(%h,%h) c=%b"},
                              want.new_vel_a_x, want.new_vel_a_y, want.new_vel_b_x,
                              want.new_vel_b_y, want.centers_coincide,
                              got.new_vel_a_x, got.new_vel_a_y, got.new_vel_b_x,
                              got.new_vel_b_y, got.centers_coincide);
               end
            end
         end
      end
   end

   initial begin
      wait (stimulus_done);
      while (expected_velocities.size() > 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      if (mismatch_count == 0 && expected_velocities.size() == 0) begin
         $display("circle_elastic_collision_response_unit verification clean");
      end else begin
         $display("circle_elastic_collision_response_unit verification failed");
      end
      $finish;
   end

   // Slowest run: ~1210 items with random gaps and stalls plus pipeline depth; allow far more.
   initial begin
      #2_000_000;
      $display("circle_elastic_collision_response_unit verification failed");
      $finish;
   end

endmodule
